// ===== hw/rtl/dds_pkg.sv =====
`timescale 1ns / 1ps
package dds_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int NCNT_W  = NODE_W + 1;
   localparam int EADDR_W = $clog2(MAX_EDGES);
   localparam int ECNT_W  = EADDR_W + 1;
   localparam int PEND_W  = ECNT_W;
   localparam int DL_W    = 16;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_DEADLINE = 2'd1,
      CMD_EDGE     = 2'd2,
      CMD_EVAL     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT  = 2'd0,
      CSR_TARGET_NODE = 2'd1,
      CSR_SPARE2      = 2'd2,
      CSR_SPARE3      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANC_E,
      ST_ANC_X,
      ST_CNT_E,
      ST_CNT_X,
      ST_CNT_W,
      ST_RINIT,
      ST_SRCH,
      ST_PICK,
      ST_DEC_E,
      ST_DEC_X,
      ST_DEC_W,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/dds_req_if.sv =====
`timescale 1ns / 1ps
interface dds_req_if import dds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [NODE_W-1:0] node;
   logic [NODE_W-1:0] other_node;
   logic [DL_W-1:0]   deadline;

   modport source (output valid, cmd, node, other_node, deadline, input ready);
   modport sink   (input valid, cmd, node, other_node, deadline, output ready);
endinterface

// ===== hw/rtl/dds_rsp_if.sv =====
`timescale 1ns / 1ps
interface dds_rsp_if import dds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              feasible;
   logic [NCNT_W-1:0] scheduled_count;
   logic              edge_overflow;

   modport source (output valid, feasible, scheduled_count, edge_overflow, input ready);
   modport sink   (input valid, feasible, scheduled_count, edge_overflow, output ready);
endinterface

// ===== hw/rtl/deadline_dag_schedule_check.sv =====
`timescale 1ns / 1ps
// Load commands (clear, set deadline, add edge) are taken one per cycle while idle.
// Evaluate: ancestor passes over the edge list repeat until none marks a node,
// then a predecessor count pass; then, per scheduled node, a deadline-RAM scan
// and a successor-update pass over the edge list.
// One item at a time; a result register lets loads continue while it waits.
// Synchronous active-high reset clears control state; deadlines read as zero.
module deadline_dag_schedule_check import dds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dds_req_if.sink               req_chan,
   dds_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [NCNT_W-1:0]    ncount_ff, ncount_in;
   logic [NODE_W-1:0]    tgt_ff, tgt_in;
   logic [ECNT_W-1:0]    etot_ff, etot_in;
   logic                 ovf_ff, ovf_in;
   logic [MAX_NODES-1:0] dlv_ff, dlv_in;
   logic [MAX_NODES-1:0] anc_ff, anc_in;
   logic [MAX_NODES-1:0] rdy_ff, rdy_in;
   logic [MAX_NODES-1:0] pvld_ff, pvld_in;
   logic [ECNT_W-1:0]    eidx_ff, eidx_in;
   logic                 chg_ff, chg_in;
   logic [NODE_W-1:0]    dst_ff, dst_in;
   logic [NCNT_W-1:0]    t_ff, t_in;
   logic [NCNT_W-1:0]    done_ff, done_in;
   logic                 feas_ff, feas_in;
   logic [NCNT_W-1:0]    sidx_ff, sidx_in;
   logic                 probe_ff, probe_in;
   logic [NODE_W-1:0]    pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [NODE_W-1:0]    best_ff, best_in;
   logic [DL_W-1:0]      bestdl_ff, bestdl_in;
   logic                 rvld_ff, rvld_in;
   logic                 rfeas_ff, rfeas_in;
   logic [NCNT_W-1:0]    rcnt_ff, rcnt_in;
   logic                 rovf_ff, rovf_in;

   // memory ports
   logic                  dl_we;
   logic [NODE_W-1:0]     dl_raddr;
   logic [DL_W-1:0]       dl_rdata;
   logic                  ed_we;
   logic [EADDR_W-1:0]    ed_raddr;
   logic [2*NODE_W-1:0]   ed_rdata;
   logic                  pd_we;
   logic [NODE_W-1:0]     pd_raddr;
   logic [PEND_W-1:0]     pd_wdata;
   logic [PEND_W-1:0]     pd_rdata;

   logic                  req_xfer, rsp_free;
   logic [NCNT_W-1:0]     n_w;
   logic [NODE_W-1:0]     e_src, e_dst;
   logic                  src_in_use, dst_in_use, last_edge, srch_end;
   logic                  anc_pull;
   logic [DL_W-1:0]       probe_dl;
   logic                  miss;
   cmd_type               cmd_w;

   assign cmd_w      = cmd_type'(req_chan.cmd);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer   = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rvld_ff || rsp_chan.ready;
   assign n_w        = (ncount_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : ncount_ff;
   assign e_src      = ed_rdata[2*NODE_W-1:NODE_W];
   assign e_dst      = ed_rdata[NODE_W-1:0];
   assign src_in_use = {1'b0, e_src} < n_w;
   assign dst_in_use = {1'b0, e_dst} < n_w;
   assign anc_pull   = src_in_use && dst_in_use && anc_ff[e_dst] && !anc_ff[e_src];
   assign last_edge  = (eidx_ff + ECNT_W'(1)) == etot_ff;
   assign srch_end   = (sidx_ff == n_w);
   assign probe_dl   = dlv_ff[pidx_ff] ? dl_rdata : '0;
   assign miss       = !found_ff || ({{(DL_W-NCNT_W){1'b0}}, t_ff} > bestdl_ff);

   // memories: deadlines, edge list, pending predecessor counts
   dds_ram #(.WIDTH(DL_W), .DEPTH(MAX_NODES)) u_dl_ram (
      .clock(clock), .wr_en(dl_we), .wr_addr(req_chan.node),
      .wr_data(req_chan.deadline), .rd_addr(dl_raddr), .rd_data(dl_rdata)
   );
   dds_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(ed_we), .wr_addr(etot_ff[EADDR_W-1:0]),
      .wr_data({req_chan.node, req_chan.other_node}), .rd_addr(ed_raddr),
      .rd_data(ed_rdata)
   );
   dds_ram #(.WIDTH(PEND_W), .DEPTH(MAX_NODES)) u_pend_ram (
      .clock(clock), .wr_en(pd_we), .wr_addr(dst_ff), .wr_data(pd_wdata),
      .rd_addr(pd_raddr), .rd_data(pd_rdata)
   );

   assign dl_we    = req_xfer && (cmd_w == CMD_DEADLINE);
   assign ed_we    = req_xfer && (cmd_w == CMD_EDGE) && (etot_ff < ECNT_W'(MAX_EDGES));
   assign ed_raddr = eidx_ff[EADDR_W-1:0];
   assign dl_raddr = sidx_ff[NODE_W-1:0];
   assign pd_raddr = e_dst;
   assign pd_we    = ((state_ff == ST_CNT_W) || (state_ff == ST_DEC_W && pd_rdata != '0));
   assign pd_wdata = (state_ff == ST_CNT_W)
                     ? ((pvld_ff[dst_ff] ? pd_rdata : '0) + PEND_W'(1))
                     : (pd_rdata - PEND_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && cmd_w == CMD_EVAL) begin
               if ({1'b0, tgt_ff} >= n_w) state_in = ST_DONE;
               else if (etot_ff == '0)    state_in = ST_RINIT;
               else                       state_in = ST_ANC_E;
            end
         end
         ST_ANC_E: state_in = ST_ANC_X;
         ST_ANC_X: begin
            if (!last_edge) state_in = ST_ANC_E;
            else if (chg_ff || anc_pull) state_in = ST_ANC_E;
            else state_in = ST_CNT_E;
         end
         ST_CNT_E: state_in = ST_CNT_X;
         ST_CNT_X: begin
            if (src_in_use && dst_in_use && anc_ff[e_src] && anc_ff[e_dst])
               state_in = ST_CNT_W;
            else if (last_edge) state_in = ST_RINIT;
            else state_in = ST_CNT_E;
         end
         ST_CNT_W: state_in = last_edge ? ST_RINIT : ST_CNT_E;
         ST_RINIT: state_in = ST_SRCH;
         ST_SRCH:  state_in = (srch_end && probe_ff) ? ST_PICK : ST_SRCH;
         ST_PICK: begin
            if (miss || best_ff == tgt_ff) state_in = ST_DONE;
            else if (etot_ff == '0)        state_in = ST_SRCH;
            else                           state_in = ST_DEC_E;
         end
         ST_DEC_E: state_in = ST_DEC_X;
         ST_DEC_X: begin
            if (e_src == best_ff && dst_in_use && anc_ff[e_dst] && pvld_ff[e_dst])
               state_in = ST_DEC_W;
            else if (last_edge) state_in = ST_SRCH;
            else state_in = ST_DEC_E;
         end
         ST_DEC_W: state_in = last_edge ? ST_SRCH : ST_DEC_E;
         ST_DONE:  state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      ncount_in = ncount_ff;
      tgt_in    = tgt_ff;
      etot_in   = etot_ff;
      ovf_in    = ovf_ff;
      dlv_in    = dlv_ff;
      anc_in    = anc_ff;
      rdy_in    = rdy_ff;
      pvld_in   = pvld_ff;
      eidx_in   = eidx_ff;
      chg_in    = chg_ff;
      dst_in    = dst_ff;
      t_in      = t_ff;
      done_in   = done_ff;
      feas_in   = feas_ff;
      sidx_in   = sidx_ff;
      probe_in  = probe_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bestdl_in = bestdl_ff;
      rvld_in   = rvld_ff && !rsp_chan.ready;
      rfeas_in  = rfeas_ff;
      rcnt_in   = rcnt_ff;
      rovf_in   = rovf_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NODE_COUNT:  ncount_in = csr_wdata[NCNT_W-1:0];
            CSR_TARGET_NODE: tgt_in    = csr_wdata[NODE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (cmd_w)
                  CMD_CLEAR: begin
                     etot_in = '0;
                     ovf_in  = 1'b0;
                  end
                  CMD_DEADLINE: dlv_in[req_chan.node] = 1'b1;
                  CMD_EDGE: begin
                     if (etot_ff < ECNT_W'(MAX_EDGES)) etot_in = etot_ff + ECNT_W'(1);
                     else ovf_in = 1'b1;
                  end
                  CMD_EVAL: begin
                     anc_in  = '0;
                     rdy_in  = '0;
                     pvld_in = '0;
                     done_in = '0;
                     t_in    = NCNT_W'(1);
                     feas_in = 1'b0;
                     eidx_in = '0;
                     chg_in  = 1'b0;
                     if ({1'b0, tgt_ff} < n_w) anc_in[tgt_ff] = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ANC_E: ;
         ST_ANC_X: begin
            // pull in the source of an edge into a marked node
            if (anc_pull) begin
               anc_in[e_src] = 1'b1;
               chg_in = 1'b1;
            end
            if (last_edge) begin
               eidx_in = '0;
               chg_in  = 1'b0;
            end else begin
               eidx_in = eidx_ff + ECNT_W'(1);
            end
         end
         ST_CNT_E: ;
         ST_CNT_X: begin
            dst_in = e_dst;
            if (!(src_in_use && dst_in_use && anc_ff[e_src] && anc_ff[e_dst]))
               eidx_in = eidx_ff + ECNT_W'(1);
         end
         ST_CNT_W: begin
            pvld_in[dst_ff] = 1'b1;
            eidx_in = eidx_ff + ECNT_W'(1);
         end
         ST_RINIT: begin
            rdy_in   = anc_ff & ~pvld_ff;
            sidx_in  = '0;
            probe_in = 1'b0;
            found_in = 1'b0;
         end
         ST_SRCH: begin
            // compare the probed node, then issue the next read
            if (probe_ff && rdy_ff[pidx_ff] && (!found_ff || probe_dl < bestdl_ff)) begin
               found_in  = 1'b1;
               best_in   = pidx_ff;
               bestdl_in = probe_dl;
            end
            if (!srch_end) begin
               pidx_in  = sidx_ff[NODE_W-1:0];
               probe_in = 1'b1;
               sidx_in  = sidx_ff + NCNT_W'(1);
            end else begin
               probe_in = 1'b0;
            end
         end
         ST_PICK: begin
            if (!miss) begin
               rdy_in[best_ff] = 1'b0;
               done_in = done_ff + NCNT_W'(1);
               t_in    = t_ff + NCNT_W'(1);
               if (best_ff == tgt_ff) feas_in = 1'b1;
            end
            eidx_in  = '0;
            sidx_in  = '0;
            probe_in = 1'b0;
            found_in = 1'b0;
         end
         ST_DEC_E: ;
         ST_DEC_X: begin
            dst_in = e_dst;
            if (!(e_src == best_ff && dst_in_use && anc_ff[e_dst] && pvld_ff[e_dst]))
               eidx_in = eidx_ff + ECNT_W'(1);
         end
         ST_DEC_W: begin
            if (pd_rdata == PEND_W'(1)) rdy_in[dst_ff] = 1'b1;
            eidx_in = eidx_ff + ECNT_W'(1);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rvld_in  = 1'b1;
               rfeas_in = feas_ff;
               rcnt_in  = done_ff;
               rovf_in  = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ncount_ff <= NCNT_W'(MAX_NODES);
         tgt_ff    <= '0;
         etot_ff   <= '0;
         ovf_ff    <= 1'b0;
         dlv_ff    <= '0;
         rvld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ncount_ff <= ncount_in;
         tgt_ff    <= tgt_in;
         etot_ff   <= etot_in;
         ovf_ff    <= ovf_in;
         dlv_ff    <= dlv_in;
         rvld_ff   <= rvld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      anc_ff    <= anc_in;
      rdy_ff    <= rdy_in;
      pvld_ff   <= pvld_in;
      eidx_ff   <= eidx_in;
      chg_ff    <= chg_in;
      dst_ff    <= dst_in;
      t_ff      <= t_in;
      done_ff   <= done_in;
      feas_ff   <= feas_in;
      sidx_ff   <= sidx_in;
      probe_ff  <= probe_in;
      pidx_ff   <= pidx_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      bestdl_ff <= bestdl_in;
      rfeas_ff  <= rfeas_in;
      rcnt_ff   <= rcnt_in;
      rovf_ff   <= rovf_in;
   end

   assign rsp_chan.valid           = rvld_ff;
   assign rsp_chan.feasible        = rfeas_ff;
   assign rsp_chan.scheduled_count = rcnt_ff;
   assign rsp_chan.edge_overflow   = rovf_ff;

   // checks
   a_feas_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.feasible |-> rsp_chan.scheduled_count != '0)
      else $error("feasible result with zero scheduled nodes");
   a_etot_bound: assert property (@(posedge clock) disable iff (reset)
      etot_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");
   a_feas_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) && !miss && (best_ff == tgt_ff) |=> state_ff == ST_DONE && feas_ff)
      else $error("target scheduled without finishing");
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> done_ff < n_w)
      else $error("more nodes scheduled than in use");
endmodule

// ===== hw/rtl/dds_ram.sv =====
`timescale 1ns / 1ps
module dds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
